@@ rtl/a64rr_pkg.sv @@
// Package with shared constants and types for the reachable-return scanner.
`timescale 1ns / 1ps
`default_nettype none

package a64rr_pkg;

    // Default body capacity in instruction words
    localparam int unsigned DEF_MAX_WORDS = 1024;

    // Input item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INDIRECT = 3'd1;
    localparam logic [2:0] ST_BAD_TGT  = 3'd2;
    localparam logic [2:0] ST_FELL_OFF = 3'd3;
    localparam logic [2:0] ST_NO_RET   = 3'd4;
    localparam logic [2:0] ST_BAD_BASE = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    // Instruction match patterns
    localparam logic [31:0] RET_X30    = 32'hd65f03c0;
    localparam logic [31:0] BRK_MASK   = 32'hffe0001f;
    localparam logic [31:0] BRK_VAL    = 32'hd4200000;
    localparam logic [31:0] BREG_MASK  = 32'hfe000000;
    localparam logic [31:0] BREG_VAL   = 32'hd6000000;
    localparam logic [31:0] B_MASK     = 32'hfc000000;
    localparam logic [31:0] B_VAL      = 32'h14000000;
    localparam logic [31:0] BCOND_MASK = 32'hff000010;
    localparam logic [31:0] BCOND_VAL  = 32'h54000000;
    localparam logic [31:0] CB_MASK    = 32'h7e000000;
    localparam logic [31:0] CBZ_VAL    = 32'h34000000;
    localparam logic [31:0] TBZ_VAL    = 32'h36000000;

    // Bits of one flag entry
    localparam int unsigned FLAG_VISITED = 0;
    localparam int unsigned FLAG_RET     = 1;

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_CHECK = 10'b0000000100,
        S_POP   = 10'b0000001000,
        S_IDX   = 10'b0000010000,
        S_DEC   = 10'b0000100000,
        S_PUSH2 = 10'b0001000000,
        S_RREQ  = 10'b0010000000,
        S_RCHK  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/a64_reachable_return_scan.sv @@
// Top level of the reachable-return scanner: loader, walk sequencer and site reader.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------
//  in       | input     | in_valid / in_stall      | mode, instr_word, last_word
//  out      | output    | out_valid / out_stall    | status, return_count, site_address,
//           |           |                          | site_instruction, last_site
//  cfg      | input     | cfg_wr_en                | cfg_wr_data (base address)
//
//  The word flagged last starts the walk: a flag clear over the loaded words, the base
//  check, then per popped stack entry a pop, memory read, decode and second push, all
//  on one stack port. A read scans the return marks entry by entry, a request and a
//  check each, until the next site is found. Reset clears all control state; the
//  memories need none. While a result waits on out_stall the next request is still
//  taken; a new result waits in the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module a64_reachable_return_scan #(
    parameter int unsigned MAX_WORDS = a64rr_pkg::DEF_MAX_WORDS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [63:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [31:0] instr_word,
    input  wire logic        last_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [10:0]      return_count,
    output logic [63:0]      site_address,
    output logic [31:0]      site_instruction,
    output logic             last_site
);

    import a64rr_pkg::*;

    localparam int unsigned IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int unsigned DEPTH  = 2 * MAX_WORDS;
    localparam int unsigned SA_W   = $clog2(DEPTH);
    localparam int unsigned SP_W   = $clog2(DEPTH + 1);
    localparam int unsigned TGT_W  = (((CNT_W + 1) > 27) ? (CNT_W + 1) : 27) + 1;

    // Control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   word_count_reg, word_count_next;
    logic [CNT_W-1:0]   read_index_reg, read_index_next;
    logic [CNT_W-1:0]   emitted_reg, emitted_next;
    logic [CNT_W-1:0]   found_reg, found_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [2:0]         walk_result_reg, walk_result_next;
    logic               overflow_reg, overflow_next;
    logic [63:0]        base_reg;
    logic [2:0]         pend_status_reg, pend_status_next;
    logic               pend_site_reg, pend_site_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;

    // Output payload
    logic [2:0]         status_reg;
    logic [10:0]        return_count_reg;
    logic [63:0]        site_address_reg;
    logic [31:0]        site_instruction_reg;
    logic               last_site_reg;

    // Memories and their ports
    logic [31:0]        code_mem [MAX_WORDS];
    logic [1:0]         flag_mem [MAX_WORDS];
    logic [IDX_W-1:0]   stack_mem [DEPTH];
    logic [31:0]        code_rd_reg;
    logic [1:0]         flag_rd_reg;
    logic [IDX_W-1:0]   stack_rd_reg;
    logic               code_we, code_re, flag_we, flag_re, stack_we, stack_re;
    logic [IDX_W-1:0]   code_wa, code_ra, flag_wa, flag_ra, stack_wd;
    logic [1:0]         flag_wd;
    logic [SA_W-1:0]    stack_wa, stack_ra;

    // Datapath helpers
    logic [CNT_W-1:0]        load_cnt;
    logic                    fresh_body;
    logic [CNT_W-1:0]        idx_inc;
    logic [64:0]             base_end;
    logic                    is_ret, is_brk, is_ind, is_b, is_b19, is_tb, is_branch;
    logic signed [TGT_W-1:0] delta, tgt;
    logic                    tgt_bad, stack_full, fall_bad;
    logic [SP_W-1:0]         sp_dec;

    assign fresh_body = (walk_result_reg != ST_EMPTY);
    assign load_cnt   = fresh_body ? '0 : word_count_reg;
    assign idx_inc    = CNT_W'(idx_reg) + CNT_W'(1);
    assign fall_bad   = (idx_inc >= word_count_reg);
    assign base_end   = {1'b0, base_reg} + {1'b0, 64'({word_count_reg, 2'b00})};
    assign stack_full = (sp_reg == SP_W'(DEPTH));
    assign sp_dec     = sp_reg - SP_W'(1);

    // Decode the fetched word
    always_comb
    begin
        is_ret = (code_rd_reg == RET_X30);
        is_brk = ((code_rd_reg & BRK_MASK) == BRK_VAL);
        is_ind = ((code_rd_reg & BREG_MASK) == BREG_VAL) &&
                 !(code_rd_reg[21] && !code_rd_reg[22]);
        is_b   = ((code_rd_reg & B_MASK) == B_VAL);
        is_b19 = ((code_rd_reg & BCOND_MASK) == BCOND_VAL) ||
                 ((code_rd_reg & CB_MASK) == CBZ_VAL);
        is_tb  = ((code_rd_reg & CB_MASK) == TBZ_VAL);
        is_branch = is_b || is_b19 || is_tb;
        if (is_b)
        begin
            delta = TGT_W'($signed(code_rd_reg[25:0]));
        end
        else if (is_b19)
        begin
            delta = TGT_W'($signed(code_rd_reg[23:5]));
        end
        else
        begin
            delta = TGT_W'($signed(code_rd_reg[18:5]));
        end
        tgt     = $signed(TGT_W'(idx_reg)) + delta;
        tgt_bad = tgt[TGT_W-1] || (tgt >= $signed(TGT_W'(word_count_reg)));
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        word_count_next  = word_count_reg;
        read_index_next  = read_index_reg;
        emitted_next     = emitted_reg;
        found_next       = found_reg;
        sp_next          = sp_reg;
        idx_next         = idx_reg;
        walk_result_next = walk_result_reg;
        overflow_next    = overflow_reg;
        pend_status_next = pend_status_reg;
        pend_site_next   = pend_site_reg;
        code_we  = 1'b0;
        code_re  = 1'b0;
        flag_we  = 1'b0;
        flag_re  = 1'b0;
        stack_we = 1'b0;
        stack_re = 1'b0;
        code_wa  = load_cnt[IDX_W-1:0];
        code_ra  = idx_reg;
        flag_wa  = idx_reg;
        flag_ra  = idx_reg;
        flag_wd  = '0;
        stack_wa = sp_reg[SA_W-1:0];
        stack_ra = sp_dec[SA_W-1:0];
        stack_wd = '0;
        out_load = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode == MODE_LOAD)
                    begin
                        // Drop the previous body on the first load after a walk
                        if (fresh_body)
                        begin
                            read_index_next  = '0;
                            emitted_next     = '0;
                            found_next       = '0;
                            walk_result_next = ST_EMPTY;
                        end
                        if (load_cnt < CNT_W'(MAX_WORDS))
                        begin
                            code_we         = 1'b1;
                            word_count_next = load_cnt + CNT_W'(1);
                            overflow_next   = overflow_reg && !fresh_body;
                        end
                        else
                        begin
                            word_count_next = load_cnt;
                            overflow_next   = 1'b1;
                        end
                        if (last_word)
                        begin
                            idx_next   = '0;
                            state_next = S_CLEAR;
                        end
                    end
                    else if (walk_result_reg == ST_OK && emitted_reg != found_reg)
                    begin
                        state_next = S_RREQ;
                    end
                    else
                    begin
                        pend_status_next = ST_EMPTY;
                        pend_site_next   = 1'b0;
                        state_next       = S_OUT;
                    end
                end
            end

            S_CLEAR:
            begin
                // Clear visited and return flags over the loaded range
                flag_we = 1'b1;
                if (CNT_W'(idx_reg) == word_count_reg - CNT_W'(1))
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_CHECK:
            begin
                found_next      = '0;
                read_index_next = '0;
                emitted_next    = '0;
                pend_site_next  = 1'b0;
                if (overflow_reg || word_count_reg == '0 || base_reg[1:0] != 2'b00 ||
                    base_end[64])
                begin
                    sp_next          = '0;
                    pend_status_next = ST_BAD_BASE;
                    walk_result_next = ST_BAD_BASE;
                    state_next       = S_OUT;
                end
                else
                begin
                    // Seed the stack with word 0
                    stack_we   = 1'b1;
                    stack_wa   = '0;
                    stack_wd   = '0;
                    sp_next    = SP_W'(1);
                    state_next = S_POP;
                end
            end

            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    pend_status_next = (found_reg == '0) ? ST_NO_RET : ST_OK;
                    walk_result_next = (found_reg == '0) ? ST_NO_RET : ST_OK;
                    state_next       = S_OUT;
                end
                else
                begin
                    stack_re   = 1'b1;
                    sp_next    = sp_dec;
                    state_next = S_IDX;
                end
            end

            S_IDX:
            begin
                // Fetch the word and its flags
                idx_next   = stack_rd_reg;
                code_re    = 1'b1;
                code_ra    = stack_rd_reg;
                flag_re    = 1'b1;
                flag_ra    = stack_rd_reg;
                state_next = S_DEC;
            end

            S_DEC:
            begin
                if (flag_rd_reg[FLAG_VISITED])
                begin
                    state_next = S_POP;
                end
                else
                begin
                    flag_we               = 1'b1;
                    flag_wd[FLAG_VISITED] = 1'b1;
                    flag_wd[FLAG_RET]     = is_ret;
                    if (is_ret)
                    begin
                        found_next = found_reg + CNT_W'(1);
                        state_next = S_POP;
                    end
                    else if (is_brk)
                    begin
                        state_next = S_POP;
                    end
                    else if (is_ind)
                    begin
                        pend_status_next = ST_INDIRECT;
                        walk_result_next = ST_INDIRECT;
                        state_next       = S_OUT;
                    end
                    else if (is_branch && tgt_bad)
                    begin
                        pend_status_next = ST_BAD_TGT;
                        walk_result_next = ST_BAD_TGT;
                        state_next       = S_OUT;
                    end
                    else if (is_branch && stack_full)
                    begin
                        pend_status_next = ST_BAD_BASE;
                        walk_result_next = ST_BAD_BASE;
                        state_next       = S_OUT;
                    end
                    else if (is_branch)
                    begin
                        // Push the target; conditional branches also fall through
                        stack_we   = 1'b1;
                        stack_wd   = tgt[IDX_W-1:0];
                        sp_next    = sp_reg + SP_W'(1);
                        state_next = is_b ? S_POP : S_PUSH2;
                    end
                    else
                    begin
                        state_next = S_PUSH2;
                    end
                end
            end

            S_PUSH2:
            begin
                if (fall_bad)
                begin
                    pend_status_next = ST_FELL_OFF;
                    walk_result_next = ST_FELL_OFF;
                    state_next       = S_OUT;
                end
                else if (stack_full)
                begin
                    pend_status_next = ST_BAD_BASE;
                    walk_result_next = ST_BAD_BASE;
                    state_next       = S_OUT;
                end
                else
                begin
                    stack_we   = 1'b1;
                    stack_wd   = idx_inc[IDX_W-1:0];
                    sp_next    = sp_reg + SP_W'(1);
                    state_next = S_POP;
                end
            end

            S_RREQ:
            begin
                // Look up the next entry of the return marks
                idx_next   = read_index_reg[IDX_W-1:0];
                code_re    = 1'b1;
                code_ra    = read_index_reg[IDX_W-1:0];
                flag_re    = 1'b1;
                flag_ra    = read_index_reg[IDX_W-1:0];
                state_next = S_RCHK;
            end

            S_RCHK:
            begin
                read_index_next = read_index_reg + CNT_W'(1);
                if (flag_rd_reg[FLAG_RET])
                begin
                    emitted_next     = emitted_reg + CNT_W'(1);
                    pend_status_next = ST_OK;
                    pend_site_next   = 1'b1;
                    state_next       = S_OUT;
                end
                else
                begin
                    state_next = S_RREQ;
                end
            end

            S_OUT:
            begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            word_count_reg  <= '0;
            read_index_reg  <= '0;
            emitted_reg     <= '0;
            found_reg       <= '0;
            sp_reg          <= '0;
            idx_reg         <= '0;
            walk_result_reg <= ST_EMPTY;
            overflow_reg    <= 1'b0;
            base_reg        <= '0;
            pend_status_reg <= ST_EMPTY;
            pend_site_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            word_count_reg  <= word_count_next;
            read_index_reg  <= read_index_next;
            emitted_reg     <= emitted_next;
            found_reg       <= found_next;
            sp_reg          <= sp_next;
            idx_reg         <= idx_next;
            walk_result_reg <= walk_result_next;
            overflow_reg    <= overflow_next;
            pend_status_reg <= pend_status_next;
            pend_site_reg   <= pend_site_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg           <= pend_status_reg;
            return_count_reg     <= (pend_status_reg == ST_OK) ? 11'(found_reg) : '0;
            site_address_reg     <= pend_site_reg ?
                                    (base_reg + 64'({idx_reg, 2'b00})) : '0;
            site_instruction_reg <= pend_site_reg ? code_rd_reg : '0;
            last_site_reg        <= pend_site_reg && (emitted_reg == found_reg);
        end
    end

    // Code store
    always_ff @(posedge clk)
    begin
        if (code_we)
        begin
            code_mem[code_wa] <= instr_word;
        end
        if (code_re)
        begin
            code_rd_reg <= code_mem[code_ra];
        end
    end

    // Visited and return flags
    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_wa] <= flag_wd;
        end
        if (flag_re)
        begin
            flag_rd_reg <= flag_mem[flag_ra];
        end
    end

    // Work stack
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_ra];
        end
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign return_count     = return_count_reg;
    assign site_address     = site_address_reg;
    assign site_instruction = site_instruction_reg;
    assign last_site        = last_site_reg;

    // Stack never grows past its depth
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SP_W'(DEPTH))
        else $error("work stack pointer beyond depth");

    // Sites handed out never exceed the sites found
    assert property (@(posedge clk) disable iff (!rst_n)
        (walk_result_reg == ST_OK) |-> (emitted_reg <= found_reg))
        else $error("more sites read than found");

    // Returns found never exceed the loaded words
    assert property (@(posedge clk) disable iff (!rst_n) found_reg <= word_count_reg)
        else $error("return count beyond body length");

    // A final site only comes with a good status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_site) |-> (status == ST_OK))
        else $error("last site flagged on a failed result");

endmodule

`default_nettype wire
